### hdl/mlf_pkg.sv
// Shared constants, codes and control structs for the MODWT level filter.
package mlf_pkg;

  // Storage sizes
  localparam int MAX_SAMPLES = 1024;
  localparam int MAX_TAPS    = 16;
  localparam int SAMPLE_AW   = $clog2(MAX_SAMPLES);
  localparam int TAP_AW      = $clog2(MAX_TAPS);

  // Field and register widths
  localparam int INDEX_W = 10;
  localparam int DATA_W  = 16;
  localparam int OUT_W   = 20;
  localparam int N_W     = 11;
  localparam int LEVEL_W = 4;
  localparam int TCNT_W  = 5;
  localparam int BCNT_W  = $clog2(INDEX_W + 1);

  // Datapath widths: a 16x16 product, summed over up to MAX_TAPS terms
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + TAP_AW + 1;
  localparam int FRAC_W = 15;

  // Operation codes
  localparam logic [1:0] OP_LOAD_TAP = 2'd0;
  localparam logic [1:0] OP_STORE    = 2'd1;
  localparam logic [1:0] OP_COMPUTE  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd0;
  localparam logic [1:0] CFG_LEVEL        = 2'd1;
  localparam logic [1:0] CFG_TAP_COUNT    = 2'd2;

  // Reset values of the configuration registers
  localparam logic [N_W-1:0]     SAMPLE_COUNT_RST = N_W'(1024);
  localparam logic [LEVEL_W-1:0] LEVEL_RST        = LEVEL_W'(1);
  localparam logic [TCNT_W-1:0]  TAP_COUNT_RST    = TCNT_W'(8);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN,
    ST_FLUSH,
    ST_DONE
  } state_t;

  // Index unit control
  typedef struct packed {
    logic start;
    logic advance;
  } iu_ctl_t;

  // Multiply-accumulate control
  typedef struct packed {
    logic clear;
    logic data_valid;
  } mac_ctl_t;

endpackage

### hdl/mlf_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
module mlf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/mlf_index_unit.sv
// Sample address walker: start index modulo N, dilation step modulo N, circular stepping.
module mlf_index_unit
  import mlf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  iu_ctl_t              ctl,
  input  logic [INDEX_W-1:0]   idx,
  input  logic [N_W-1:0]       n_len,
  input  logic [LEVEL_W-1:0]   lvl,
  output logic                 done,
  output logic [SAMPLE_AW-1:0] k
);

  logic [SAMPLE_AW-1:0] rem;
  logic [SAMPLE_AW-1:0] rem_next;
  logic [INDEX_W-1:0]   qbits;
  logic [BCNT_W-1:0]    bcnt;
  logic [SAMPLE_AW-1:0] step;
  logic [SAMPLE_AW-1:0] step_next;
  logic [LEVEL_W-1:0]   dcnt;
  logic [SAMPLE_AW-1:0] k_next;
  logic [N_W-1:0]       r2;
  logic [N_W-1:0]       s2;
  logic [SAMPLE_AW:0]   diff;
  logic [SAMPLE_AW:0]   wrapped;

  // Restoring remainder, one index bit a cycle
  always_comb begin
    r2 = N_W'({rem, qbits[INDEX_W-1]});
    if (r2 >= n_len) begin
      r2 = r2 - n_len;
    end
    rem_next = r2[SAMPLE_AW-1:0];
  end

  // Dilation 2^(j-1) mod N by repeated doubling
  always_comb begin
    s2 = N_W'({step, 1'b0});
    if (s2 >= n_len) begin
      s2 = s2 - n_len;
    end
    step_next = s2[SAMPLE_AW-1:0];
  end

  // Circular step back by the dilation
  always_comb begin
    diff    = {1'b0, rem} - {1'b0, step};
    wrapped = diff + (SAMPLE_AW + 1)'(n_len);
    k_next  = diff[SAMPLE_AW] ? wrapped[SAMPLE_AW-1:0] : diff[SAMPLE_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bcnt <= '0;
      dcnt <= '0;
    end else if (ctl.start) begin
      bcnt <= BCNT_W'(INDEX_W);
      dcnt <= (lvl == '0) ? '0 : lvl - LEVEL_W'(1);
    end else begin
      if (bcnt != '0) begin
        bcnt <= bcnt - BCNT_W'(1);
      end
      if (dcnt != '0) begin
        dcnt <= dcnt - LEVEL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem   <= '0;
      qbits <= idx;
      step  <= (n_len == N_W'(1)) ? '0 : SAMPLE_AW'(1);
    end else begin
      if (bcnt != '0) begin
        rem   <= rem_next;
        qbits <= {qbits[INDEX_W-2:0], 1'b0};
      end else if (ctl.advance) begin
        rem <= k_next;
      end
      if (dcnt != '0) begin
        step <= step_next;
      end
    end
  end

  assign done = (bcnt == '0) && (dcnt == '0);
  assign k    = rem;

endmodule

### hdl/mlf_mac.sv
// Dual multiply-accumulate with product register, floor shift and 20-bit saturation.
module mlf_mac
  import mlf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] sample,
  input  logic signed [DATA_W-1:0] high_tap,
  input  logic signed [DATA_W-1:0] low_tap,
  output logic signed [OUT_W-1:0]  wavelet_sum,
  output logic signed [OUT_W-1:0]  scaling_sum
);

  localparam int SH_W = ACC_W - FRAC_W;

  logic signed [PROD_W-1:0] prod_h;
  logic signed [PROD_W-1:0] prod_l;
  logic                     prod_valid;
  logic signed [ACC_W-1:0]  acc_h;
  logic signed [ACC_W-1:0]  acc_l;

  // Saturate a shifted sum to the output width
  function automatic logic signed [OUT_W-1:0] sat(input logic signed [ACC_W-1:0] acc);
    logic signed [SH_W-1:0] sh;
    logic                   fits;
    sh   = SH_W'(acc >>> FRAC_W);
    fits = (sh[SH_W-1:OUT_W-1] == '0) || (sh[SH_W-1:OUT_W-1] == '1);
    if (fits) begin
      sat = sh[OUT_W-1:0];
    end else if (sh[SH_W-1]) begin
      sat = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

  // Product stage
  always_ff @(posedge clk) begin
    prod_h <= high_tap * sample;
    prod_l <= low_tap * sample;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl.data_valid;
    end
  end

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_h <= '0;
      acc_l <= '0;
    end else if (prod_valid) begin
      acc_h <= acc_h + ACC_W'(prod_h);
      acc_l <= acc_l + ACC_W'(prod_l);
    end
  end

  assign wavelet_sum = sat(acc_h);
  assign scaling_sum = sat(acc_l);

endmodule

### hdl/modwt_level_filter.sv
// Top level of the MODWT level filter: control FSM, sample and tap RAMs, output register.
//
// Use: each input word carries an operation. A tap load writes a high/low tap pair, a
// sample store writes one sample; neither gives a result. A compute word
// for time t gives one result word with t, the wavelet sum and the scaling sum.
// Input channel: in_valid/in_stall; the block holds in_stall high while it works on a
// compute word and takes one word at a time. Output channel: out_valid/out_stall; the
// result sits in an output register, so the next word is taken while it waits.
// Configuration: cfg_valid/cfg_ready (always ready), cfg_index selects sample_count,
// level or tap_count; write only while the block is idle.
// A compute word runs a setup phase, in which the start index remainder (one bit a cycle)
// and the dilation doubling run side by side; then the run phase reads one tap pair per
// cycle through the one read port of the sample RAM, L pairs for tap count L; then a
// flush phase drains the read and product registers and the done state loads the result.
// If the receiver stalls, a finished result waits in the FSM until the register frees.
// Reset: configuration returns to N = 1024, level 1, L = 8, the pipeline empties; the
// RAM contents are undefined until written.
module modwt_level_filter
  import mlf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               operation,
  input  logic [INDEX_W-1:0]       index,
  input  logic signed [DATA_W-1:0] sample_value,
  input  logic signed [DATA_W-1:0] high_tap,
  input  logic signed [DATA_W-1:0] low_tap,
  // output channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [INDEX_W-1:0]       time_index,
  output logic signed [OUT_W-1:0]  wavelet_coef,
  output logic signed [OUT_W-1:0]  scaling_coef,
  // configuration channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [N_W-1:0]           cfg_data
);

  state_t state;
  state_t state_next;

  logic [N_W-1:0]      sample_count;
  logic [LEVEL_W-1:0]  level;
  logic [TCNT_W-1:0]   tap_count;
  logic [N_W-1:0]      n_len;
  logic [TCNT_W-1:0]   taps_used;

  logic                in_accept;
  logic                out_take;
  logic [INDEX_W-1:0]  t_hold;
  logic [TAP_AW-1:0]   tap_cnt;
  logic                last_tap;
  logic                flush_cnt;
  logic                rd_valid;

  logic                issue;
  logic                out_load;
  logic                smp_we;
  logic                tap_we;
  iu_ctl_t             iu_ctl;
  mac_ctl_t            mac_ctl;
  logic                iu_done;
  logic [SAMPLE_AW-1:0] k;

  logic [DATA_W-1:0]   smp_rdata;
  logic [2*DATA_W-1:0] tap_rdata;
  logic signed [OUT_W-1:0] wavelet_sum;
  logic signed [OUT_W-1:0] scaling_sum;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= SAMPLE_COUNT_RST;
      level        <= LEVEL_RST;
      tap_count    <= TAP_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SAMPLE_COUNT: sample_count <= cfg_data;
        CFG_LEVEL:        level        <= cfg_data[LEVEL_W-1:0];
        CFG_TAP_COUNT:    tap_count    <= cfg_data[TCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp N and L to their legal ranges
  always_comb begin
    if (sample_count == '0) begin
      n_len = N_W'(1);
    end else if (sample_count > N_W'(MAX_SAMPLES)) begin
      n_len = N_W'(MAX_SAMPLES);
    end else begin
      n_len = sample_count;
    end
    if (tap_count == '0) begin
      taps_used = TCNT_W'(1);
    end else if (tap_count > TCNT_W'(MAX_TAPS)) begin
      taps_used = TCNT_W'(MAX_TAPS);
    end else begin
      taps_used = tap_count;
    end
  end

  assign last_tap = (TCNT_W'(tap_cnt) == taps_used - TCNT_W'(1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && operation == OP_COMPUTE) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (iu_done) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_tap) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (flush_cnt) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_stall           = 1'b1;
    issue              = 1'b0;
    out_load           = 1'b0;
    smp_we             = 1'b0;
    tap_we             = 1'b0;
    iu_ctl             = '0;
    mac_ctl.clear      = 1'b0;
    mac_ctl.data_valid = rd_valid;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          unique case (operation)
            OP_LOAD_TAP: tap_we = (index < INDEX_W'(MAX_TAPS));
            OP_STORE:    smp_we = (N_W'(index) < N_W'(MAX_SAMPLES));
            OP_COMPUTE: begin
              iu_ctl.start  = 1'b1;
              mac_ctl.clear = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        issue          = 1'b1;
        iu_ctl.advance = 1'b1;
      end
      ST_DONE: begin
        out_load = !out_valid || !out_stall;
      end
      default: ;
    endcase
  end

  // State, tap counter and read pipeline flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tap_cnt   <= '0;
      flush_cnt <= 1'b0;
      rd_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (state == ST_RUN) begin
        tap_cnt <= tap_cnt + TAP_AW'(1);
      end else begin
        tap_cnt <= '0;
      end
      flush_cnt <= (state == ST_FLUSH) ? !flush_cnt : 1'b0;
    end
  end

  // Hold the output time of the word in progress
  always_ff @(posedge clk) begin
    if (in_accept && operation == OP_COMPUTE) begin
      t_hold <= index;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      time_index   <= t_hold;
      wavelet_coef <= wavelet_sum;
      scaling_coef <= scaling_sum;
    end
  end

  mlf_index_unit u_index (
    .clk   (clk),
    .rst   (rst),
    .ctl   (iu_ctl),
    .idx   (index),
    .n_len (n_len),
    .lvl   (level),
    .done  (iu_done),
    .k     (k)
  );

  mlf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_SAMPLES)
  ) u_samples (
    .clk   (clk),
    .we    (smp_we),
    .waddr (index[SAMPLE_AW-1:0]),
    .wdata (sample_value),
    .raddr (k),
    .rdata (smp_rdata)
  );

  mlf_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (MAX_TAPS)
  ) u_taps (
    .clk   (clk),
    .we    (tap_we),
    .waddr (index[TAP_AW-1:0]),
    .wdata ({high_tap, low_tap}),
    .raddr (tap_cnt),
    .rdata (tap_rdata)
  );

  mlf_mac u_mac (
    .clk         (clk),
    .rst         (rst),
    .ctl         (mac_ctl),
    .sample      (smp_rdata),
    .high_tap    (tap_rdata[2*DATA_W-1:DATA_W]),
    .low_tap     (tap_rdata[DATA_W-1:0]),
    .wavelet_sum (wavelet_sum),
    .scaling_sum (scaling_sum)
  );

  // The address walker must have finished its setup before any tap is issued
  a_run_after_setup: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> iu_done)
    else $error("tap issued before index setup finished");

  // The tap counter never runs past the tap count in use
  a_tap_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (TCNT_W'(tap_cnt) < taps_used))
    else $error("tap counter beyond tap count");

  // A compute word starts the setup phase
  a_compute_starts: assert property (@(posedge clk) disable iff (rst)
    (in_accept && operation == OP_COMPUTE) |=> (state == ST_PREP))
    else $error("compute word did not start setup");

  // A new result appears only out of the done state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside done state");

  // No RAM read is in flight when the result is taken from the accumulators
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> !rd_valid)
    else $error("read still in flight at result time");

endmodule

### tb/modwt_level_filter_test.sv
// Self-checking testbench for the MODWT level filter: queued driver, predictor, result monitor.
module modwt_level_filter_test
  import mlf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 50;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_WORDS    = 250;
  localparam longint COEF_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint COEF_MIN = -(longint'(1) <<< (OUT_W - 1));

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [INDEX_W-1:0] idx;
    logic [DATA_W-1:0]  sample;
    logic [DATA_W-1:0]  high;
    logic [DATA_W-1:0]  low;
  } filter_word_t;

  typedef struct packed {
    logic [INDEX_W-1:0] t;
    logic [OUT_W-1:0]   wavelet;
    logic [OUT_W-1:0]   scaling;
  } coef_word_t;

  // DUT connections
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              operation;
  logic [INDEX_W-1:0]      index;
  logic [DATA_W-1:0]       sample_value;
  logic [DATA_W-1:0]       high_tap;
  logic [DATA_W-1:0]       low_tap;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [INDEX_W-1:0]      time_index;
  logic signed [OUT_W-1:0] wavelet_coef;
  logic signed [OUT_W-1:0] scaling_coef;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [1:0]              cfg_index = '0;
  logic [N_W-1:0]          cfg_data = '0;

  filter_word_t offered = '0;
  assign operation    = offered.op;
  assign index        = offered.idx;
  assign sample_value = offered.sample;
  assign high_tap     = offered.high;
  assign low_tap      = offered.low;

  modwt_level_filter dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .index        (index),
    .sample_value (sample_value),
    .high_tap     (high_tap),
    .low_tap      (low_tap),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .time_index   (time_index),
    .wavelet_coef (wavelet_coef),
    .scaling_coef (scaling_coef),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: sample series, tap bank, register copies
  logic [DATA_W-1:0]  sample_mem [MAX_SAMPLES];
  logic [DATA_W-1:0]  tap_high [MAX_TAPS];
  logic [DATA_W-1:0]  tap_low [MAX_TAPS];
  logic [N_W-1:0]     reg_n     = SAMPLE_COUNT_RST;
  logic [LEVEL_W-1:0] reg_level = LEVEL_RST;
  logic [TCNT_W-1:0]  reg_taps  = TAP_COUNT_RST;

  // Generator bookkeeping: which entries hold data already
  bit sample_written [MAX_SAMPLES];
  bit tap_written [MAX_TAPS];

  filter_word_t pending[$];
  coef_word_t   coef_queue[$];
  int           words_queued = 0;
  int           words_accepted = 0;
  int           live_words = 0;
  int           fail_count = 0;
  int           idle_cycles = 0;
  int           holdoff_req = 0;
  int           holdoff_seen = 0;
  int           holdoff_left = 0;
  idle_mode_t   idle_mode = IDLE_NONE;

  function automatic int series_len();
    if (reg_n == 0) return 1;
    if (reg_n > MAX_SAMPLES) return MAX_SAMPLES;
    return int'(reg_n);
  endfunction

  function automatic int taps_used();
    if (reg_taps == 0) return 1;
    if (reg_taps > MAX_TAPS) return MAX_TAPS;
    return int'(reg_taps);
  endfunction

  // Sample address read by tap n for output time t (circular, dilated)
  function automatic int read_addr(int t, int n);
    int len;
    int lv;
    int dil;
    len = series_len();
    lv  = int'(reg_level);
    dil = (lv == 0) ? 1 : (1 << (lv - 1));
    return (t % len + len - (n * (dil % len)) % len) % len;
  endfunction

  // Drop 15 fraction bits (floor) and clamp to the 20-bit range
  function automatic logic [OUT_W-1:0] scale_coef(longint acc);
    longint q;
    q = acc >>> FRAC_W;
    if (q > COEF_MAX) q = COEF_MAX;
    else if (q < COEF_MIN) q = COEF_MIN;
    return q[OUT_W-1:0];
  endfunction

  function automatic coef_word_t filter_coefs(logic [INDEX_W-1:0] t);
    coef_word_t r;
    longint     accw;
    longint     accv;
    longint     x;
    int         k;
    accw = 0;
    accv = 0;
    for (int n = 0; n < taps_used(); n++) begin
      k = read_addr(int'(t), n);
      x = longint'($signed(sample_mem[k[SAMPLE_AW-1:0]]));
      accw += longint'($signed(tap_high[n[TAP_AW-1:0]])) * x;
      accv += longint'($signed(tap_low[n[TAP_AW-1:0]])) * x;
    end
    r.t       = t;
    r.wavelet = scale_coef(accw);
    r.scaling = scale_coef(accv);
    return r;
  endfunction

  // Apply one accepted input word to the predictor
  function automatic void filter_step(filter_word_t w);
    case (w.op)
      OP_LOAD_TAP: begin
        if (w.idx < MAX_TAPS) begin
          tap_high[w.idx[TAP_AW-1:0]] = w.high;
          tap_low[w.idx[TAP_AW-1:0]]  = w.low;
        end
      end
      OP_STORE: begin
        sample_mem[w.idx] = w.sample;
      end
      OP_COMPUTE: begin
        coef_queue.push_back(filter_coefs(w.idx));
      end
      default: begin
        // unused code: no effect, no result
      end
    endcase
  endfunction

  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 46;
      IDLE_BOTH:   return $urandom_range(99) < 32;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_gap();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(99) < 46;
      IDLE_BOTH:     return $urandom_range(99) < 32;
      default:       return 1'b0;
    endcase
  endfunction

  // Full-scale values show up often so that saturation is reached
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic queue_item(logic [1:0] op, int idx, logic [DATA_W-1:0] v,
                            logic [DATA_W-1:0] h, logic [DATA_W-1:0] l);
    filter_word_t w;
    w.op     = op;
    w.idx    = INDEX_W'(idx);
    w.sample = v;
    w.high   = h;
    w.low    = l;
    pending.push_back(w);
    words_queued++;
    if (op == OP_LOAD_TAP && w.idx < MAX_TAPS) begin
      tap_written[w.idx[TAP_AW-1:0]] = 1'b1;
      live_words++;
    end else if (op == OP_STORE) begin
      sample_written[w.idx] = 1'b1;
      live_words++;
    end else if (op == OP_COMPUTE) begin
      live_words++;
    end
  endtask

  task automatic queue_random(logic [1:0] op, int idx);
    queue_item(op, idx, pick_value(), pick_value(), pick_value());
  endtask

  // A compute word, preceded by writes of any tap or sample it would read unwritten
  task automatic queue_compute(int t);
    int k;
    for (int n = 0; n < taps_used(); n++) begin
      if (!tap_written[n[TAP_AW-1:0]]) queue_random(OP_LOAD_TAP, n);
      k = read_addr(t, n);
      if (!sample_written[k[SAMPLE_AW-1:0]]) queue_random(OP_STORE, k);
    end
    queue_random(OP_COMPUTE, t);
  endtask

  task automatic random_phase(int count);
    int goal;
    int roll;
    goal = live_words + count;
    while (live_words < goal) begin
      roll = $urandom_range(99);
      if (roll < 45) queue_compute($urandom_range(1023));
      else if (roll < 70) queue_random(OP_STORE, $urandom_range(1023));
      else if (roll < 88)
        queue_random(OP_LOAD_TAP, ($urandom_range(4) == 0) ? $urandom_range(1023)
                                                           : $urandom_range(MAX_TAPS - 1));
      else queue_random(OP_UNUSED, $urandom_range(1023));
    end
  endtask

  // Wait until every word is taken and every result is back, then let the pipe settle
  task automatic wait_idle();
    while (!(words_accepted == words_queued && coef_queue.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(logic [1:0] idx, logic [N_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_regs(logic [N_W-1:0] n, logic [LEVEL_W-1:0] j, logic [TCNT_W-1:0] l);
    put_reg(CFG_SAMPLE_COUNT, n);
    put_reg(CFG_LEVEL, N_W'(j));
    put_reg(CFG_TAP_COUNT, N_W'(l));
    cfg_valid <= 1'b0;
    reg_n     = n;
    reg_level = j;
    reg_taps  = l;
  endtask

  // Input driver: offers queued words, feeds the predictor on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        filter_step(offered);
        words_accepted <= words_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending.size() != 0 && !sender_gap()) begin
          offered  <= pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall, including the long hold-off
  always @(posedge clk) begin : coef_monitor
    coef_word_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (coef_queue.size() == 0) begin
          $error("result word with no compute pending: time_index %0d", time_index);
          fail_count++;
        end else begin
          want = coef_queue.pop_front();
          if (time_index !== want.t) begin
            $error("time_index: expected %0d, actual %0d", want.t, time_index);
            fail_count++;
          end
          if (wavelet_coef !== want.wavelet) begin
            $error("wavelet_coef: expected %0d, actual %0d", $signed(want.wavelet),
                   wavelet_coef);
            fail_count++;
          end
          if (scaling_coef !== want.scaling) begin
            $error("scaling_coef: expected %0d, actual %0d", $signed(want.scaling),
                   scaling_coef);
            fail_count++;
          end
        end
      end
      if (holdoff_seen != holdoff_req) begin
        holdoff_seen <= holdoff_req;
        holdoff_left <= HOLDOFF_CYCLES;
      end else if (holdoff_left > 0) begin
        holdoff_left <= holdoff_left - 1;
      end
      out_stall <= (holdoff_left > 0) || receiver_gap();
    end
  end

  // Watchdog: too long without any word moving on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus sequence
  initial begin
    for (int i = 0; i < MAX_SAMPLES; i++) sample_written[i[SAMPLE_AW-1:0]] = 1'b0;
    for (int i = 0; i < MAX_TAPS; i++) tap_written[i[TAP_AW-1:0]] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: two-sample series, level 0, all 16 taps at full scale
    write_regs(2, 0, 16);
    for (int n = 0; n < MAX_TAPS; n++) queue_item(OP_LOAD_TAP, n, pick_value(), 16'h8000, 16'h7fff);
    // tap loads past the bank are ignored
    queue_item(OP_LOAD_TAP, MAX_TAPS, pick_value(), 16'h7fff, 16'h7fff);
    queue_item(OP_LOAD_TAP, 1023, pick_value(), 16'h7fff, 16'h7fff);
    queue_item(OP_STORE, 0, 16'h8000, pick_value(), pick_value());
    queue_item(OP_STORE, 1, 16'h8000, pick_value(), pick_value());
    queue_item(OP_STORE, 1023, 16'h7fff, pick_value(), pick_value());
    queue_random(OP_UNUSED, 0);
    // high-pass sum overflows and saturates
    queue_random(OP_COMPUTE, 0);
    // time past the series wraps, reported as given
    queue_random(OP_COMPUTE, 1023);
    queue_item(OP_STORE, 0, 16'h7fff, pick_value(), pick_value());
    queue_item(OP_STORE, 1, 16'h7fff, pick_value(), pick_value());
    queue_random(OP_COMPUTE, 1);
    wait_idle();

    // Full series and taps; receiver holds off while the sender keeps offering
    idle_mode <= IDLE_NONE;
    write_regs(1024, 1, 16);
    holdoff_req <= holdoff_req + 1;
    random_phase(PHASE_WORDS);
    wait_idle();

    // Smallest sizes; sender pauses midway until all results are back
    idle_mode <= IDLE_SENDER;
    write_regs(1, 0, 1);
    random_phase(PHASE_WORDS / 2);
    wait_idle();
    random_phase(PHASE_WORDS / 2);
    wait_idle();

    // Register values above the clamps, widest dilation
    idle_mode <= IDLE_RECEIVER;
    write_regs(2047, 15, 31);
    random_phase(PHASE_WORDS);
    wait_idle();

    // Zero registers clamp up
    idle_mode <= IDLE_BOTH;
    write_regs(0, 10, 0);
    random_phase(PHASE_WORDS);
    wait_idle();

    // Random settings, mostly short series
    for (int i = 0; i < 4; i++) begin
      idle_mode <= idle_mode_t'(i % 4);
      write_regs(($urandom_range(1) != 0) ? N_W'($urandom_range(64, 2))
                                          : N_W'($urandom_range(1024, 2)),
                 LEVEL_W'($urandom_range(15)), TCNT_W'($urandom_range(31)));
      random_phase(PHASE_WORDS);
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/mlf_pkg.sv
hdl/mlf_ram.sv
hdl/mlf_index_unit.sv
hdl/mlf_mac.sv
hdl/modwt_level_filter.sv
tb/modwt_level_filter_test.sv
